>>> hdl/kpq_pkg.sv
// Shared types, sizes and status codes for the keyed priority queue.
`timescale 1ns / 1ps

package kpq_pkg;

   localparam int DEPTH       = 16;
   localparam int KEY_BITS    = 16;
   localparam int PRIO_BITS   = 32;
   localparam int COUNT_BITS  = $clog2(DEPTH + 1);
   localparam int STATUS_BITS = 3;
   localparam int CMD_BITS    = 1;

   localparam int REQ_FIELD_BITS = KEY_BITS + PRIO_BITS;
   localparam int REQ_DATA_BITS  = ((REQ_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS = 2 * KEY_BITS + 2 * PRIO_BITS + 1 + COUNT_BITS;
   localparam int RSP_DATA_BITS  = ((RSP_FIELD_BITS + 7) / 8) * 8;

   localparam logic [CMD_BITS-1:0] CMD_PUSH = 1'b0;
   localparam logic [CMD_BITS-1:0] CMD_POP  = 1'b1;

   localparam logic [STATUS_BITS-1:0] STATUS_INSERTED = 3'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_UPDATED  = 3'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_POPPED   = 3'd2;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL     = 3'd3;
   localparam logic [STATUS_BITS-1:0] STATUS_EMPTY    = 3'd4;

   typedef logic        [KEY_BITS-1:0]  key_type;
   typedef logic signed [PRIO_BITS-1:0] prio_type;

   typedef struct packed {
      logic     valid;
      key_type  key;
      prio_type prio;
   } entry_type;

   // Broadcast to every cell in a cycle
   typedef struct packed {
      logic     remove;   // close the gap at the first marked cell
      logic     insert;   // open a gap at the sorted place and drop the key in
      key_type  key;
      prio_type prio;
   } cell_op_type;

   // a ranks above b: higher priority, ties go to the smaller key
   function automatic logic outranks(key_type a_key, prio_type a_prio,
                                     key_type b_key, prio_type b_prio);
      logic result;
      if (a_prio != b_prio) begin
         result = (a_prio > b_prio);
      end else begin
         result = (a_key < b_key);
      end
      return result;
   endfunction

endpackage

>>> hdl/kpq_cell.sv
// One slot of the sorted entry chain; trades entries with its two neighbors.
`timescale 1ns / 1ps

module kpq_cell import kpq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cell_op_type op,
   input  entry_type   above,         // entry of the neighbor nearer the top
   input  entry_type   below,         // entry of the neighbor farther from the top
   input  logic        mark_in,       // key hit (or pop) somewhere above this cell
   input  logic        gt_prev_in,    // new item outranks the neighbor above
   output logic        mark_out,
   output logic        gt_out,
   output entry_type   entry
);

   entry_type ent_ff;
   entry_type ent_in;
   logic      hit;

   assign hit      = ent_ff.valid && (ent_ff.key == op.key);
   assign mark_out = mark_in || hit;
   assign gt_out   = !ent_ff.valid || outranks(op.key, op.prio, ent_ff.key, ent_ff.prio);
   assign entry    = ent_ff;

   always_comb begin
      ent_in = ent_ff;
      if (op.remove) begin
         if (mark_out) begin
            ent_in = below;
         end
      end else if (op.insert) begin
         if (gt_prev_in) begin
            ent_in = above;
         end else if (gt_out) begin
            ent_in.valid = 1'b1;
            ent_in.key   = op.key;
            ent_in.prio  = op.prio;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_ff.valid <= 1'b0;
      end else begin
         ent_ff.valid <= ent_in.valid;
      end
      ent_ff.key  <= ent_in.key;
      ent_ff.prio <= ent_in.prio;
   end

endmodule

>>> hdl/keyed_priority_queue_update.sv
// Top level of the keyed max-priority queue built as a sorted chain of cells.
`timescale 1ns / 1ps

// Keyed max-priority queue of up to DEPTH entries. The entries sit in a chain of
// cells kept sorted at all times, cell 0 holding the top (highest priority, ties
// to the smaller key), so the top is always read straight from cell 0. Every cell
// compares the incoming key and priority in parallel and moves one place up or
// down with its neighbors. A pop closes the gap at cell 0; a push of a new key
// opens a gap at its sorted place; a push of a held key first closes the gap at
// that key and then reinserts it with its new priority. One item is handled at a
// time: an accepted item passes from ST_IDLE to ST_RESP (through ST_INSERT for an
// update, which needs a removal and an insertion pass through the chain), where its
// result is loaded into the output register, and req_tready returns with that load. The
// result register holds the last result until it is taken; a new item is
// accepted meanwhile, but its own result waits for that register to clear.

module keyed_priority_queue_update import kpq_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,

   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,   // key, priority_req
   input  logic [CMD_BITS-1:0]      req_tuser,   // command

   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // popped_key, popped_priority, top_valid, top_key, top_priority, entry_count
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,
   output logic [STATUS_BITS-1:0]   rsp_tuser    // status
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_INSERT = 2'd1;
   localparam logic [1:0] ST_RESP   = 2'd2;

   logic [1:0]            state_ff, state_in;
   key_type               key_ff;
   prio_type              prio_ff;
   logic [STATUS_BITS-1:0] status_ff, status_in;
   key_type               pkey_ff, pkey_in;
   prio_type              pprio_ff, pprio_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_BITS-1:0] rsp_data_ff, rsp_data_in;
   logic [STATUS_BITS-1:0]   rsp_user_ff, rsp_user_in;

   key_type     req_key;
   prio_type    req_prio;
   logic        accept;
   logic        is_pop;
   logic        full;
   logic        key_held;
   cell_op_type op;

   entry_type   ent   [DEPTH];
   logic        mark  [DEPTH+1];
   logic        gt    [DEPTH+1];

   entry_type   top;
   key_type     top_key;
   prio_type    top_prio;

   assign req_key  = req_tdata[KEY_BITS-1:0];
   assign req_prio = req_tdata[KEY_BITS +: PRIO_BITS];
   assign req_tready = (state_ff == ST_IDLE);
   assign accept   = req_tvalid && req_tready;
   assign is_pop   = (req_tuser == CMD_POP);
   assign full     = (count_ff == COUNT_BITS'(DEPTH));

   // Key match ripples down the chain; at cell 0 a pop forces the mark so the
   // whole chain shifts up by one.
   assign mark[0] = (state_ff == ST_IDLE) && is_pop;
   assign gt[0]   = 1'b0;
   assign key_held = mark[DEPTH];

   always_comb begin
      op.key    = (state_ff == ST_IDLE) ? req_key  : key_ff;
      op.prio   = (state_ff == ST_IDLE) ? req_prio : prio_ff;
      op.remove = 1'b0;
      op.insert = 1'b0;
      if (accept) begin
         if (is_pop) begin
            op.remove = (count_ff != '0);
         end else if (key_held) begin
            op.remove = 1'b1;
         end else begin
            op.insert = !full;
         end
      end else if (state_ff == ST_INSERT) begin
         op.insert = 1'b1;
      end
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      entry_type above, below;
      if (i == 0) begin : g_head
         assign above = '0;
      end else begin : g_mid
         assign above = ent[i-1];
      end
      if (i == DEPTH - 1) begin : g_tail
         assign below = '0;
      end else begin : g_body
         assign below = ent[i+1];
      end
      kpq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .op         (op),
         .above      (above),
         .below      (below),
         .mark_in    (mark[i]),
         .gt_prev_in (gt[i]),
         .mark_out   (mark[i+1]),
         .gt_out     (gt[i+1]),
         .entry      (ent[i])
      );
   end

   assign top      = ent[0];
   assign top_key  = top.valid ? top.key  : '0;
   assign top_prio = top.valid ? top.prio : '0;

   // Control and result capture
   always_comb begin
      state_in     = state_ff;
      status_in    = status_ff;
      pkey_in      = pkey_ff;
      pprio_in     = pprio_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               pkey_in  = '0;
               pprio_in = '0;
               state_in = ST_RESP;
               if (is_pop) begin
                  if (count_ff == '0) begin
                     status_in = STATUS_EMPTY;
                  end else begin
                     status_in = STATUS_POPPED;
                     pkey_in   = top.key;
                     pprio_in  = top.prio;
                     count_in  = count_ff - 1'b1;
                  end
               end else if (key_held) begin
                  status_in = STATUS_UPDATED;
                  state_in  = ST_INSERT;
               end else if (full) begin
                  status_in = STATUS_FULL;
               end else begin
                  status_in = STATUS_INSERTED;
                  count_in  = count_ff + 1'b1;
               end
            end
         end
         ST_INSERT: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = status_ff;
               rsp_data_in  = RSP_DATA_BITS'({count_ff, top_prio, top_key, top.valid,
                                              pprio_ff, pkey_ff});
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         key_ff  <= req_key;
         prio_ff <= req_prio;
      end
      status_ff   <= status_in;
      pkey_ff     <= pkey_in;
      pprio_ff    <= pprio_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule
